// ===== rtl/core/lsra_pkg.sv =====
// lsra_pkg: shared types, codes and constants of the linear scan register allocator
// used by every module under rtl/core; depends on nothing
package lsra_pkg;

   // field widths
   localparam int ID_W        = 12;
   localparam int POS_W       = 12;
   localparam int POOL_W      = 2;
   localparam int REG_W       = 4;
   localparam int REG_OUT_W   = 3;
   localparam int SLOT_W      = 10;
   localparam int SLOTS_W     = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   // active set
   localparam int ACT_DEPTH   = 16;
   localparam int ACT_IDX_W   = 4;
   localparam int ACT_CNT_W   = 5;
   localparam logic [ACT_CNT_W-1:0] ACT_FULL = 5'd16;

   // register pools are held in masks of this many bits
   localparam int POOL_MAX    = 16;

   // parameter defaults
   localparam int INT_REGS_DEF           = 6;
   localparam int FLOAT_SCRATCH_REGS_DEF = 6;
   localparam int FLOAT_SAVED_REGS_DEF   = 4;
   localparam int MAX_RANGES_DEF         = 1024;
   localparam int SLOT_FIELD_LIMIT       = 1024;

   // configuration reset values
   localparam logic [5:0] CFG_INT_RST = 6'd60;
   localparam logic [5:0] CFG_FSC_RST = 6'd60;
   localparam logic [3:0] CFG_FSV_RST = 4'd15;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INT_FREE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FSC_FREE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FSV_FREE = 2'd2;

   // pool codes
   localparam logic [POOL_W-1:0] POOL_INT = 2'd0;
   localparam logic [POOL_W-1:0] POOL_FSC = 2'd1;
   localparam logic [POOL_W-1:0] POOL_FSV = 2'd2;

   // register class codes
   localparam logic KIND_INT = 1'b0;
   localparam logic KIND_FLT = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [POS_W-1:0]  fin;
      logic              kind;
      logic [POOL_W-1:0] pool;
      logic [REG_W-1:0]  rnum;
   } act_entry_type;

   typedef struct packed {
      logic [ACT_IDX_W-1:0] rd_idx;
      logic                 from_begin;
      logic [POS_W-1:0]     key;
      logic                 wr_en;
      logic [ACT_IDX_W-1:0] wr_idx;
      act_entry_type        wr_data;
      logic                 sh_en;
      logic [ACT_IDX_W-1:0] sh_from;
   } act_ctl_type;

   typedef struct packed {
      logic              take;
      logic              take_kind;
      logic              give;
      logic [POOL_W-1:0] give_pool;
      logic [REG_W-1:0]  give_reg;
      logic              slot_take;
      logic              restart;
   } pool_cmd_type;

   typedef struct packed {
      logic              avail;
      logic [POOL_W-1:0] pool;
      logic [REG_W-1:0]  rnum;
   } pool_grant_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_ALLOC,
      ST_VSCAN,
      ST_INSERT,
      ST_OUT0,
      ST_OUT1
   } seq_state_type;

endpackage

// ===== rtl/core/linear_scan_register_allocator.sv =====
// linear_scan_register_allocator: one live range per request beat, one or two result beats.
// steps: accept, expire the ranges that have ended, allocate, scan for a victim when allocation
//   fails and the set is not empty, insert while moving entries with a larger end up one place,
//   then the result beats; a spill into an empty set goes straight to the result beats
// throughput: one range at a time, the next is taken the cycle after its last result beat
// reset: synchronous, clears sequencer, active count, slot counter, and loads pools and csr
module linear_scan_register_allocator #(
   parameter int INT_REGS           = lsra_pkg::INT_REGS_DEF,
   parameter int FLOAT_SCRATCH_REGS = lsra_pkg::FLOAT_SCRATCH_REGS_DEF,
   parameter int FLOAT_SAVED_REGS   = lsra_pkg::FLOAT_SAVED_REGS_DEF,
   parameter int MAX_RANGES         = lsra_pkg::MAX_RANGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lsra_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsra_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lsra_pkg::ID_W-1:0]         req_value_id,
   input  logic [lsra_pkg::POS_W-1:0]        req_range_begin,
   input  logic [lsra_pkg::POS_W-1:0]        req_range_finish,
   input  logic                              req_value_kind,
   input  logic                              req_last_range,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lsra_pkg::ID_W-1:0]         rsp_out_id,
   output logic                              rsp_spilled,
   output logic [lsra_pkg::POOL_W-1:0]       rsp_pool,
   output logic [lsra_pkg::REG_OUT_W-1:0]    rsp_reg_number,
   output logic [lsra_pkg::SLOT_W-1:0]       rsp_slot_number,
   output logic [lsra_pkg::SLOTS_W-1:0]      rsp_slots_used,
   output logic                              rsp_final_result
);

   lsra_pkg::act_ctl_type    act_ctl;
   lsra_pkg::act_entry_type  rd_entry;
   logic                     lt;
   lsra_pkg::pool_cmd_type   pool_cmd;
   lsra_pkg::pool_grant_type grant;
   logic [lsra_pkg::SLOT_W-1:0]  slot;
   logic [lsra_pkg::SLOTS_W-1:0] next_slot;

   lsra_active u_active (
      .clock    (clock),
      .ctl      (act_ctl),
      .rd_entry (rd_entry),
      .lt       (lt)
   );

   lsra_pools #(
      .INT_REGS           (INT_REGS),
      .FLOAT_SCRATCH_REGS (FLOAT_SCRATCH_REGS),
      .FLOAT_SAVED_REGS   (FLOAT_SAVED_REGS),
      .MAX_RANGES         (MAX_RANGES)
   ) u_pools (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (pool_cmd),
      .grant     (grant),
      .slot      (slot),
      .next_slot (next_slot)
   );

   lsra_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value_id     (req_value_id),
      .req_range_begin  (req_range_begin),
      .req_range_finish (req_range_finish),
      .req_value_kind   (req_value_kind),
      .req_last_range   (req_last_range),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_id       (rsp_out_id),
      .rsp_spilled      (rsp_spilled),
      .rsp_pool         (rsp_pool),
      .rsp_reg_number   (rsp_reg_number),
      .rsp_slot_number  (rsp_slot_number),
      .rsp_slots_used   (rsp_slots_used),
      .rsp_final_result (rsp_final_result),
      .act_ctl          (act_ctl),
      .rd_entry         (rd_entry),
      .lt               (lt),
      .pool_cmd         (pool_cmd),
      .grant            (grant),
      .slot             (slot),
      .next_slot        (next_slot)
   );

endmodule

// ===== rtl/core/lsra_active.sv =====
// lsra_active: active range set kept sorted by end, with the shared end compare unit
// depends on lsra_pkg
module lsra_active (
   input  logic                    clock,
   input  lsra_pkg::act_ctl_type   ctl,
   output lsra_pkg::act_entry_type rd_entry,
   output logic                    lt
);

   lsra_pkg::act_entry_type ent_ff [lsra_pkg::ACT_DEPTH];

   logic [lsra_pkg::POS_W-1:0] cmp_a;
   logic [lsra_pkg::POS_W-1:0] cmp_b;

   assign rd_entry = ent_ff[ctl.rd_idx];

   // expiry tests end < begin, scans test finish < end
   always_comb begin
      if (ctl.from_begin) begin
         cmp_a = rd_entry.fin;
         cmp_b = ctl.key;
      end else begin
         cmp_a = ctl.key;
         cmp_b = rd_entry.fin;
      end
      lt = cmp_a < cmp_b;
   end

   always_ff @(posedge clock) begin
      if (ctl.sh_en) begin
         for (int i = 0; i < lsra_pkg::ACT_DEPTH - 1; i++) begin
            if (lsra_pkg::ACT_IDX_W'(i) >= ctl.sh_from) begin
               ent_ff[i] <= ent_ff[i+1];
            end
         end
      end else if (ctl.wr_en) begin
         ent_ff[ctl.wr_idx] <= ctl.wr_data;
      end
   end

endmodule

// ===== rtl/core/lsra_pools.sv =====
// lsra_pools: configuration registers, free register masks and spill slot counter
// depends on lsra_pkg
module lsra_pools #(
   parameter int INT_REGS           = lsra_pkg::INT_REGS_DEF,
   parameter int FLOAT_SCRATCH_REGS = lsra_pkg::FLOAT_SCRATCH_REGS_DEF,
   parameter int FLOAT_SAVED_REGS   = lsra_pkg::FLOAT_SAVED_REGS_DEF,
   parameter int MAX_RANGES         = lsra_pkg::MAX_RANGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lsra_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsra_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  lsra_pkg::pool_cmd_type            cmd,
   output lsra_pkg::pool_grant_type          grant,
   output logic [lsra_pkg::SLOT_W-1:0]       slot,
   output logic [lsra_pkg::SLOTS_W-1:0]      next_slot
);

   localparam logic [lsra_pkg::POOL_MAX-1:0] INT_LIM =
      lsra_pkg::POOL_MAX'((32'd1 << INT_REGS) - 32'd1);
   localparam logic [lsra_pkg::POOL_MAX-1:0] FSC_LIM =
      lsra_pkg::POOL_MAX'((32'd1 << FLOAT_SCRATCH_REGS) - 32'd1);
   localparam logic [lsra_pkg::POOL_MAX-1:0] FSV_LIM =
      lsra_pkg::POOL_MAX'((32'd1 << FLOAT_SAVED_REGS) - 32'd1);
   localparam int SLOT_CAP = (MAX_RANGES < lsra_pkg::SLOT_FIELD_LIMIT) ?
                             MAX_RANGES : lsra_pkg::SLOT_FIELD_LIMIT;
   localparam logic [lsra_pkg::SLOTS_W-1:0] CAP_V  = lsra_pkg::SLOTS_W'(SLOT_CAP);
   localparam logic [lsra_pkg::SLOT_W-1:0]  CAP_M1 = lsra_pkg::SLOT_W'(SLOT_CAP - 1);

   logic [5:0] cfg_int_ff, cfg_int_in;
   logic [5:0] cfg_fsc_ff, cfg_fsc_in;
   logic [3:0] cfg_fsv_ff, cfg_fsv_in;

   logic [lsra_pkg::POOL_MAX-1:0] int_ff, int_in;
   logic [lsra_pkg::POOL_MAX-1:0] fsc_ff, fsc_in;
   logic [lsra_pkg::POOL_MAX-1:0] fsv_ff, fsv_in;
   logic [lsra_pkg::SLOTS_W-1:0]  next_ff, next_in;

   logic [lsra_pkg::POOL_MAX-1:0] take_bit;
   logic [lsra_pkg::POOL_MAX-1:0] give_bit;
   logic                          slot_room;

   function automatic logic [lsra_pkg::REG_W-1:0] lowest_set(
      input logic [lsra_pkg::POOL_MAX-1:0] m
   );
      logic [lsra_pkg::REG_W-1:0] r;
      r = '0;
      for (int i = lsra_pkg::POOL_MAX - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = lsra_pkg::REG_W'(i);
         end
      end
      return r;
   endfunction

   // float ranges fall back to the saved pool when scratch is empty
   always_comb begin
      if (cmd.take_kind == lsra_pkg::KIND_INT) begin
         grant.avail = |int_ff;
         grant.pool  = lsra_pkg::POOL_INT;
         grant.rnum  = lowest_set(int_ff);
      end else if (|fsc_ff) begin
         grant.avail = 1'b1;
         grant.pool  = lsra_pkg::POOL_FSC;
         grant.rnum  = lowest_set(fsc_ff);
      end else begin
         grant.avail = |fsv_ff;
         grant.pool  = lsra_pkg::POOL_FSV;
         grant.rnum  = lowest_set(fsv_ff);
      end
   end

   assign slot_room = next_ff < CAP_V;
   assign slot      = slot_room ? next_ff[lsra_pkg::SLOT_W-1:0] : CAP_M1;
   assign next_slot = next_ff;

   always_comb begin
      take_bit = lsra_pkg::POOL_MAX'(1) << grant.rnum;
      give_bit = lsra_pkg::POOL_MAX'(1) << cmd.give_reg;

      cfg_int_in = cfg_int_ff;
      cfg_fsc_in = cfg_fsc_ff;
      cfg_fsv_in = cfg_fsv_ff;
      if (csr_we) begin
         case (csr_index)
            lsra_pkg::CSR_INT_FREE: cfg_int_in = csr_wdata;
            lsra_pkg::CSR_FSC_FREE: cfg_fsc_in = csr_wdata;
            lsra_pkg::CSR_FSV_FREE: cfg_fsv_in = csr_wdata[3:0];
            default: ;
         endcase
      end

      int_in  = int_ff;
      fsc_in  = fsc_ff;
      fsv_in  = fsv_ff;
      next_in = next_ff;
      if (cmd.restart) begin
         int_in  = {10'd0, cfg_int_ff} & INT_LIM;
         fsc_in  = {10'd0, cfg_fsc_ff} & FSC_LIM;
         fsv_in  = {12'd0, cfg_fsv_ff} & FSV_LIM;
         next_in = '0;
      end else begin
         if (cmd.take && grant.avail) begin
            case (grant.pool)
               lsra_pkg::POOL_INT: int_in = int_ff & ~take_bit;
               lsra_pkg::POOL_FSC: fsc_in = fsc_ff & ~take_bit;
               default:            fsv_in = fsv_ff & ~take_bit;
            endcase
         end
         if (cmd.give) begin
            case (cmd.give_pool)
               lsra_pkg::POOL_INT: int_in = int_ff | give_bit;
               lsra_pkg::POOL_FSC: fsc_in = fsc_ff | give_bit;
               default:            fsv_in = fsv_ff | give_bit;
            endcase
         end
         if (cmd.slot_take) begin
            next_in = slot_room ? next_ff + 11'd1 : CAP_V;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_int_ff <= lsra_pkg::CFG_INT_RST;
         cfg_fsc_ff <= lsra_pkg::CFG_FSC_RST;
         cfg_fsv_ff <= lsra_pkg::CFG_FSV_RST;
         int_ff     <= {10'd0, lsra_pkg::CFG_INT_RST} & INT_LIM;
         fsc_ff     <= {10'd0, lsra_pkg::CFG_FSC_RST} & FSC_LIM;
         fsv_ff     <= {12'd0, lsra_pkg::CFG_FSV_RST} & FSV_LIM;
         next_ff    <= '0;
      end else begin
         cfg_int_ff <= cfg_int_in;
         cfg_fsc_ff <= cfg_fsc_in;
         cfg_fsv_ff <= cfg_fsv_in;
         int_ff     <= int_in;
         fsc_ff     <= fsc_in;
         fsv_ff     <= fsv_in;
         next_ff    <= next_in;
      end
   end

endmodule

// ===== rtl/core/lsra_ctrl.sv =====
// lsra_ctrl: sequencer that expires, allocates, scans for a victim and inserts,
// then presents the result beats; depends on lsra_pkg
module lsra_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsra_pkg::ID_W-1:0]           req_value_id,
   input  logic [lsra_pkg::POS_W-1:0]          req_range_begin,
   input  logic [lsra_pkg::POS_W-1:0]          req_range_finish,
   input  logic                                req_value_kind,
   input  logic                                req_last_range,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lsra_pkg::ID_W-1:0]           rsp_out_id,
   output logic                                rsp_spilled,
   output logic [lsra_pkg::POOL_W-1:0]         rsp_pool,
   output logic [lsra_pkg::REG_OUT_W-1:0]      rsp_reg_number,
   output logic [lsra_pkg::SLOT_W-1:0]         rsp_slot_number,
   output logic [lsra_pkg::SLOTS_W-1:0]        rsp_slots_used,
   output logic                                rsp_final_result,
   output lsra_pkg::act_ctl_type               act_ctl,
   input  lsra_pkg::act_entry_type             rd_entry,
   input  logic                                lt,
   output lsra_pkg::pool_cmd_type              pool_cmd,
   input  lsra_pkg::pool_grant_type            grant,
   input  logic [lsra_pkg::SLOT_W-1:0]         slot,
   input  logic [lsra_pkg::SLOTS_W-1:0]        next_slot
);

   lsra_pkg::seq_state_type state_ff, state_in;

   logic [lsra_pkg::ACT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [lsra_pkg::ACT_IDX_W-1:0] idx_ff, idx_in;

   logic [lsra_pkg::ID_W-1:0]   id_ff, id_in;
   logic [lsra_pkg::POS_W-1:0]  begin_ff, begin_in;
   logic [lsra_pkg::POS_W-1:0]  fin_ff, fin_in;
   logic                        kind_ff, kind_in;
   logic                        last_ff, last_in;
   logic [lsra_pkg::POOL_W-1:0] cur_pool_ff, cur_pool_in;
   logic [lsra_pkg::REG_W-1:0]  cur_reg_ff, cur_reg_in;

   logic                        r0_spill_ff, r0_spill_in;
   logic [lsra_pkg::POOL_W-1:0] r0_pool_ff, r0_pool_in;
   logic [lsra_pkg::REG_W-1:0]  r0_reg_ff, r0_reg_in;
   logic [lsra_pkg::SLOT_W-1:0] r0_slot_ff, r0_slot_in;
   logic [lsra_pkg::ID_W-1:0]   r1_id_ff, r1_id_in;
   logic [lsra_pkg::POOL_W-1:0] r1_pool_ff, r1_pool_in;
   logic [lsra_pkg::SLOT_W-1:0] r1_slot_ff, r1_slot_in;
   logic                        two_ff, two_in;

   logic                           can_take;
   logic                           expire_hit;
   logic                           kind_match;
   logic                           final_beat;
   logic [lsra_pkg::ACT_CNT_W-1:0] cnt_dec;
   lsra_pkg::act_entry_type        cur_entry;

   assign can_take   = (cnt_ff != lsra_pkg::ACT_FULL) && grant.avail;
   assign expire_hit = (cnt_ff != '0) && lt;
   assign kind_match = rd_entry.kind == kind_ff;
   assign cnt_dec    = cnt_ff - 5'd1;
   assign final_beat = rsp_ready &&
                       ((state_ff == lsra_pkg::ST_OUT1) ||
                        (state_ff == lsra_pkg::ST_OUT0 && !two_ff));
   assign cur_entry  = '{id: id_ff, fin: fin_ff, kind: kind_ff,
                         pool: cur_pool_ff, rnum: cur_reg_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsra_pkg::ST_IDLE: begin
            if (req_valid) state_in = lsra_pkg::ST_EXPIRE;
         end
         lsra_pkg::ST_EXPIRE: begin
            if (!expire_hit) state_in = lsra_pkg::ST_ALLOC;
         end
         lsra_pkg::ST_ALLOC: begin
            if (can_take)          state_in = lsra_pkg::ST_INSERT;
            else if (cnt_ff == '0) state_in = lsra_pkg::ST_OUT0;
            else                   state_in = lsra_pkg::ST_VSCAN;
         end
         lsra_pkg::ST_VSCAN: begin
            if (kind_match)        state_in = lt ? lsra_pkg::ST_INSERT : lsra_pkg::ST_OUT0;
            else if (idx_ff == '0) state_in = lsra_pkg::ST_OUT0;
         end
         lsra_pkg::ST_INSERT: begin
            if (idx_ff == '0 || !lt) state_in = lsra_pkg::ST_OUT0;
         end
         lsra_pkg::ST_OUT0: begin
            if (rsp_ready) state_in = two_ff ? lsra_pkg::ST_OUT1 : lsra_pkg::ST_IDLE;
         end
         lsra_pkg::ST_OUT1: begin
            if (rsp_ready) state_in = lsra_pkg::ST_IDLE;
         end
         default: state_in = lsra_pkg::ST_IDLE;
      endcase
   end

   // commands to the active set and the pools
   always_comb begin
      act_ctl            = '0;
      act_ctl.rd_idx     = idx_ff;
      act_ctl.key        = fin_ff;
      act_ctl.wr_data    = cur_entry;
      act_ctl.wr_idx     = idx_ff;
      pool_cmd           = '0;
      pool_cmd.take_kind = kind_ff;
      pool_cmd.give_pool = rd_entry.pool;
      pool_cmd.give_reg  = rd_entry.rnum;
      pool_cmd.restart   = final_beat && last_ff;
      case (state_ff)
         lsra_pkg::ST_EXPIRE: begin
            act_ctl.rd_idx     = '0;
            act_ctl.from_begin = 1'b1;
            act_ctl.key        = begin_ff;
            act_ctl.sh_en      = expire_hit;
            pool_cmd.give      = expire_hit;
         end
         lsra_pkg::ST_ALLOC: begin
            pool_cmd.take      = can_take;
            pool_cmd.slot_take = !can_take && (cnt_ff == '0);
         end
         lsra_pkg::ST_VSCAN: begin
            pool_cmd.slot_take = kind_match || (idx_ff == '0);
            act_ctl.sh_en      = kind_match && lt;
            act_ctl.sh_from    = idx_ff;
         end
         lsra_pkg::ST_INSERT: begin
            act_ctl.rd_idx = idx_ff - 4'd1;
            act_ctl.wr_en  = 1'b1;
            // move the larger end up one place, else drop the new range in
            if (idx_ff != '0 && lt) act_ctl.wr_data = rd_entry;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      id_in       = id_ff;
      begin_in    = begin_ff;
      fin_in      = fin_ff;
      kind_in     = kind_ff;
      last_in     = last_ff;
      cur_pool_in = cur_pool_ff;
      cur_reg_in  = cur_reg_ff;
      r0_spill_in = r0_spill_ff;
      r0_pool_in  = r0_pool_ff;
      r0_reg_in   = r0_reg_ff;
      r0_slot_in  = r0_slot_ff;
      r1_id_in    = r1_id_ff;
      r1_pool_in  = r1_pool_ff;
      r1_slot_in  = r1_slot_ff;
      two_in      = two_ff;
      case (state_ff)
         lsra_pkg::ST_IDLE: begin
            if (req_valid) begin
               id_in    = req_value_id;
               begin_in = req_range_begin;
               fin_in   = req_range_finish;
               kind_in  = req_value_kind;
               last_in  = req_last_range;
               two_in   = 1'b0;
            end
         end
         lsra_pkg::ST_EXPIRE: begin
            if (expire_hit) cnt_in = cnt_dec;
         end
         lsra_pkg::ST_ALLOC: begin
            if (can_take) begin
               cur_pool_in = grant.pool;
               cur_reg_in  = grant.rnum;
               r0_spill_in = 1'b0;
               r0_pool_in  = grant.pool;
               r0_reg_in   = grant.rnum;
               r0_slot_in  = '0;
               idx_in      = cnt_ff[lsra_pkg::ACT_IDX_W-1:0];
            end else if (cnt_ff == '0) begin
               r0_spill_in = 1'b1;
               r0_pool_in  = {1'b0, kind_ff};
               r0_reg_in   = '0;
               r0_slot_in  = slot;
            end else begin
               idx_in = cnt_dec[lsra_pkg::ACT_IDX_W-1:0];
            end
         end
         lsra_pkg::ST_VSCAN: begin
            if (kind_match && lt) begin
               // steal: victim leaves the set, current range takes its register
               cur_pool_in = rd_entry.pool;
               cur_reg_in  = rd_entry.rnum;
               r0_spill_in = 1'b0;
               r0_pool_in  = rd_entry.pool;
               r0_reg_in   = rd_entry.rnum;
               r0_slot_in  = '0;
               r1_id_in    = rd_entry.id;
               r1_pool_in  = {1'b0, rd_entry.kind};
               r1_slot_in  = slot;
               two_in      = 1'b1;
               cnt_in      = cnt_dec;
               idx_in      = cnt_dec[lsra_pkg::ACT_IDX_W-1:0];
            end else if (kind_match || idx_ff == '0) begin
               r0_spill_in = 1'b1;
               r0_pool_in  = {1'b0, kind_ff};
               r0_reg_in   = '0;
               r0_slot_in  = slot;
            end else begin
               idx_in = idx_ff - 4'd1;
            end
         end
         lsra_pkg::ST_INSERT: begin
            if (idx_ff != '0 && lt) idx_in = idx_ff - 4'd1;
            else                    cnt_in = cnt_ff + 5'd1;
         end
         default: ;
      endcase
      if (final_beat && last_ff) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsra_pkg::ST_IDLE;
         cnt_ff   <= '0;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         two_ff   <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      begin_ff    <= begin_in;
      fin_ff      <= fin_in;
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      cur_pool_ff <= cur_pool_in;
      cur_reg_ff  <= cur_reg_in;
      r0_spill_ff <= r0_spill_in;
      r0_pool_ff  <= r0_pool_in;
      r0_reg_ff   <= r0_reg_in;
      r0_slot_ff  <= r0_slot_in;
      r1_id_ff    <= r1_id_in;
      r1_pool_ff  <= r1_pool_in;
      r1_slot_ff  <= r1_slot_in;
   end

   // result beats come straight from registers
   always_comb begin
      req_ready        = state_ff == lsra_pkg::ST_IDLE;
      rsp_valid        = (state_ff == lsra_pkg::ST_OUT0) || (state_ff == lsra_pkg::ST_OUT1);
      rsp_slots_used   = next_slot;
      rsp_final_result = (state_ff == lsra_pkg::ST_OUT1) || !two_ff;
      if (state_ff == lsra_pkg::ST_OUT1) begin
         rsp_out_id      = r1_id_ff;
         rsp_spilled     = 1'b1;
         rsp_pool        = r1_pool_ff;
         rsp_reg_number  = '0;
         rsp_slot_number = r1_slot_ff;
      end else begin
         rsp_out_id      = id_ff;
         rsp_spilled     = r0_spill_ff;
         rsp_pool        = r0_pool_ff;
         rsp_reg_number  = r0_reg_ff[lsra_pkg::REG_OUT_W-1:0];
         rsp_slot_number = r0_slot_ff;
      end
   end

endmodule
